FILE: src/owee_pkg.sv
// Shared types and codes for the 1-Wire EEPROM function-command unit.
// Holds the phase and sequencer enums, action codes and command bytes.
// No dependencies.
package owee_pkg;

  // Protocol phase of the command layer
  typedef enum logic [3:0] {
    PH_CMD,
    PH_ADDR,
    PH_CONFIRM,
    PH_WR_MAIN,
    PH_RD_SCR,
    PH_RD_MEM,
    PH_WR_APP,
    PH_RD_APP,
    PH_STATUS,
    PH_IDLE
  } phase_t;

  // Per-item sequencer
  typedef enum logic [2:0] {
    ST_ACCEPT,
    ST_EXEC,
    ST_MOD,
    ST_MOD_LAST,
    ST_RD_WAIT,
    ST_COPY,
    ST_COPY_LAST,
    ST_DONE
  } state_t;

  // Bus actions
  localparam logic [1:0] ACT_BUS_RESET = 2'd0;
  localparam logic [1:0] ACT_WRITE     = 2'd1;
  localparam logic [1:0] ACT_READ      = 2'd2;

  // Function commands
  localparam logic [7:0] CMD_WR_SCR    = 8'h0F;
  localparam logic [7:0] CMD_RD_SCR    = 8'hAA;
  localparam logic [7:0] CMD_CP_SCR    = 8'h55;
  localparam logic [7:0] CMD_RD_MEM    = 8'hF0;
  localparam logic [7:0] CMD_WR_APP    = 8'h99;
  localparam logic [7:0] CMD_RD_STATUS = 8'h66;
  localparam logic [7:0] CMD_RD_APP    = 8'hC3;
  localparam logic [7:0] CMD_CP_LOCK   = 8'h5A;

  // Confirmation bytes, lock bits and the undriven bus value
  localparam logic [7:0] COPY_CONFIRM   = 8'hA5;
  localparam logic [7:0] STATUS_CONFIRM = 8'h00;
  localparam logic [7:0] LOCK_MASK      = 8'h03;
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;

endpackage

FILE: src/onewire_eeprom_slave_commands_unit.sv
// Byte-level function-command layer of a 1-Wire EEPROM slave.
// Each accepted beat runs ST_EXEC and ends in ST_DONE; an address byte adds ST_MOD, ST_MOD_LAST
// (reciprocal reduction), a data read ST_RD_WAIT, a copy ST_COPY (one byte a cycle)
// and ST_COPY_LAST. One beat is handled at a time; a reply held by out_tready stalls the input.
// Reset (rst_n, synchronous): phase awaits a command, lock status 0xFF, all store
// bytes read as zero through per-entry valid bits; no clearing pass.
module onewire_eeprom_slave_commands_unit
  import owee_pkg::*;
#(
  parameter int MAIN_BYTES = 32,
  parameter int APP_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] read_byte, [8] command_error, [15:9] zero
  output logic [0:0]  out_tuser   // [0] read_driven
);

  localparam int STORE_BYTES = MAIN_BYTES + APP_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PTR_MAX     = (MAIN_BYTES > APP_BYTES) ? MAIN_BYTES : APP_BYTES;
  localparam int PTR_W       = $clog2(PTR_MAX);
  // Scaled reciprocals: floor(d * RECIP / 2^16) equals floor(d / N) for any byte d
  localparam int MAIN_RECIP  = (65536 + MAIN_BYTES - 1) / MAIN_BYTES;
  localparam int APP_RECIP   = (65536 + APP_BYTES - 1) / APP_BYTES;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [7:0]          lock_r, lock_nxt;
  logic [1:0]          act_r;
  logic [7:0]          din_r;
  logic [7:0]          quo_r, quo_nxt;
  logic [ADDR_W-1:0]   copy_addr_r, copy_addr_nxt;
  logic [ADDR_W-1:0]   copy_end_r, copy_end_nxt;
  logic                copy_pend_r;
  logic [ADDR_W-1:0]   copy_wa_r;
  logic [7:0]          res_byte_r, res_byte_nxt;
  logic                res_drv_r, res_drv_nxt;
  logic                res_err_r, res_err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic                out_drv_r;
  logic                out_err_r;
  logic                scr_vld_r [STORE_BYTES];
  logic                mem_vld_r [STORE_BYTES];
  logic                scr_ok_r;
  logic                mem_ok_r;

  logic                in_fire;
  logic                out_free;
  logic                load_out;
  logic                is_app_cmd;
  logic                app_area;
  logic                unlocked;
  logic                do_copy;
  logic                do_mod;
  logic                do_rd;
  logic                scr_we;
  logic [ADDR_W-1:0]   area_addr;
  logic [ADDR_W-1:0]   scr_raddr;
  logic [7:0]          scr_rdata;
  logic [7:0]          mem_rdata;
  logic [7:0]          scr_byte;
  logic [7:0]          mem_byte;
  logic [PTR_W-1:0]    ptr_inc;
  logic [7:0]          modulus;
  logic [15:0]         recip;
  logic [23:0]         quo_prod;
  logic [15:0]         back_prod;
  logic [7:0]          rem_val;

  // Handshake and shared decode
  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_ACCEPT);
  assign out_free   = !out_valid_r || out_tready;
  assign load_out   = (state_r == ST_DONE) && out_free;
  assign is_app_cmd = (cmd_r == CMD_WR_APP) || (cmd_r == CMD_RD_APP);
  assign app_area   = (phase_r == PH_WR_APP) || (phase_r == PH_RD_APP);
  assign unlocked   = (lock_r & LOCK_MASK) != 8'h00;
  assign do_mod     = (act_r == ACT_WRITE) && (phase_r == PH_ADDR);
  assign do_copy    = (act_r == ACT_WRITE) && (phase_r == PH_CONFIRM) &&
                      (din_r == COPY_CONFIRM) &&
                      ((cmd_r == CMD_CP_SCR) || ((cmd_r == CMD_CP_LOCK) && unlocked));
  assign do_rd      = (act_r == ACT_READ) &&
                      ((phase_r == PH_RD_SCR) || (phase_r == PH_RD_MEM) ||
                       (phase_r == PH_RD_APP));

  // Store address of the current pointer and its wrapped increment
  assign area_addr = app_area ? ADDR_W'(MAIN_BYTES) + ADDR_W'(ptr_r) : ADDR_W'(ptr_r);
  always_comb begin
    if (app_area) begin
      ptr_inc = (ptr_r == PTR_W'(APP_BYTES - 1)) ? '0 : ptr_r + 1'b1;
    end else begin
      ptr_inc = (ptr_r == PTR_W'(MAIN_BYTES - 1)) ? '0 : ptr_r + 1'b1;
    end
  end

  // Address reduction: quotient by reciprocal multiply, then remainder by back-multiply
  assign modulus   = is_app_cmd ? 8'(APP_BYTES) : 8'(MAIN_BYTES);
  assign recip     = is_app_cmd ? 16'(APP_RECIP) : 16'(MAIN_RECIP);
  assign quo_prod  = {16'h0000, din_r} * {8'h00, recip};
  assign back_prod = {8'h00, quo_r} * {8'h00, modulus};
  assign rem_val   = din_r - back_prod[7:0];

  // Store memories; unwritten entries read as zero
  assign scr_we    = (state_r == ST_EXEC) && (act_r == ACT_WRITE) &&
                     ((phase_r == PH_WR_MAIN) || (phase_r == PH_WR_APP));
  assign scr_raddr = (state_r == ST_COPY) ? copy_addr_r : area_addr;
  assign scr_byte  = scr_ok_r ? scr_rdata : 8'h00;
  assign mem_byte  = mem_ok_r ? mem_rdata : 8'h00;

  owee_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_scratch_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (area_addr),
    .wdata (din_r),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  owee_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_memory_ram (
    .clk   (clk),
    .we    (copy_pend_r),
    .waddr (copy_wa_r),
    .wdata (scr_byte),
    .raddr (area_addr),
    .rdata (mem_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCEPT: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (do_mod) state_nxt = ST_MOD;
        else if (do_copy) state_nxt = ST_COPY;
        else if (do_rd) state_nxt = ST_RD_WAIT;
        else state_nxt = ST_DONE;
      end
      ST_MOD: state_nxt = ST_MOD_LAST;
      ST_MOD_LAST: state_nxt = ST_DONE;
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_COPY: begin
        if (copy_addr_r == copy_end_r) state_nxt = ST_COPY_LAST;
      end
      ST_COPY_LAST: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_ACCEPT;
      end
      default: state_nxt = ST_ACCEPT;
    endcase
  end

  // Protocol state, pointer, lock and result next values
  always_comb begin
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    ptr_nxt       = ptr_r;
    lock_nxt      = lock_r;
    quo_nxt       = quo_r;
    copy_addr_nxt = copy_addr_r;
    copy_end_nxt  = copy_end_r;
    res_byte_nxt  = res_byte_r;
    res_drv_nxt   = res_drv_r;
    res_err_nxt   = res_err_r;
    unique case (state_r)
      ST_EXEC: begin
        res_byte_nxt = IDLE_BYTE;
        res_drv_nxt  = 1'b0;
        res_err_nxt  = 1'b0;
        if (act_r == ACT_BUS_RESET) begin
          phase_nxt = PH_CMD;
        end else if (act_r == ACT_WRITE) begin
          case (phase_r)
            PH_CMD: begin
              cmd_nxt = din_r;
              case (din_r) inside
                CMD_WR_SCR, CMD_RD_SCR, CMD_RD_MEM, CMD_WR_APP, CMD_RD_APP:
                  phase_nxt = PH_ADDR;
                CMD_CP_SCR, CMD_CP_LOCK, CMD_RD_STATUS:
                  phase_nxt = PH_CONFIRM;
                default: begin
                  res_err_nxt = 1'b1;
                  phase_nxt   = PH_IDLE;
                end
              endcase
            end
            PH_CONFIRM: begin
              phase_nxt = PH_IDLE;
              if ((cmd_r == CMD_RD_STATUS) && (din_r == STATUS_CONFIRM)) begin
                phase_nxt = PH_STATUS;
              end
              if (cmd_r == CMD_CP_SCR) begin
                copy_addr_nxt = '0;
                copy_end_nxt  = ADDR_W'(MAIN_BYTES - 1);
              end else begin
                copy_addr_nxt = ADDR_W'(MAIN_BYTES);
                copy_end_nxt  = ADDR_W'(STORE_BYTES - 1);
              end
              if (do_copy && (cmd_r == CMD_CP_LOCK)) begin
                lock_nxt = lock_r & ~LOCK_MASK;
              end
            end
            PH_WR_MAIN, PH_WR_APP: ptr_nxt = ptr_inc;
            default: ;
          endcase
        end else if (act_r == ACT_READ) begin
          if (do_rd) begin
            ptr_nxt = ptr_inc;
          end else if (phase_r == PH_STATUS) begin
            res_byte_nxt = lock_r;
            res_drv_nxt  = 1'b1;
            phase_nxt    = PH_IDLE;
          end
        end
      end
      ST_MOD: quo_nxt = quo_prod[23:16];
      ST_MOD_LAST: begin
        ptr_nxt = rem_val[PTR_W-1:0];
        if (cmd_r == CMD_RD_APP) phase_nxt = PH_RD_APP;
        else if (cmd_r == CMD_WR_APP) phase_nxt = unlocked ? PH_WR_APP : PH_IDLE;
        else if (cmd_r == CMD_WR_SCR) phase_nxt = PH_WR_MAIN;
        else if (cmd_r == CMD_RD_SCR) phase_nxt = PH_RD_SCR;
        else phase_nxt = PH_RD_MEM;
      end
      ST_RD_WAIT: begin
        res_byte_nxt = (phase_r == PH_RD_MEM) ? mem_byte : scr_byte;
        res_drv_nxt  = 1'b1;
      end
      ST_COPY: copy_addr_nxt = copy_addr_r + 1'b1;
      default: ;
    endcase
  end

  // Output register next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      phase_r     <= PH_CMD;
      cmd_r       <= 8'h00;
      ptr_r       <= '0;
      lock_r      <= IDLE_BYTE;
      copy_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      ptr_r       <= ptr_nxt;
      lock_r      <= lock_nxt;
      copy_pend_r <= (state_r == ST_COPY);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Valid bits of both stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        scr_vld_r[i] <= 1'b0;
        mem_vld_r[i] <= 1'b0;
      end
    end else begin
      if (scr_we) scr_vld_r[area_addr] <= 1'b1;
      if (copy_pend_r) mem_vld_r[copy_wa_r] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_tuser;
      din_r <= in_tdata;
    end
    quo_r       <= quo_nxt;
    copy_addr_r <= copy_addr_nxt;
    copy_end_r  <= copy_end_nxt;
    copy_wa_r   <= copy_addr_r;
    res_byte_r  <= res_byte_nxt;
    res_drv_r   <= res_drv_nxt;
    res_err_r   <= res_err_nxt;
    scr_ok_r    <= scr_vld_r[scr_raddr];
    mem_ok_r    <= mem_vld_r[area_addr];
    if (load_out) begin
      out_byte_r <= res_byte_r;
      out_drv_r  <= res_drv_r;
      out_err_r  <= res_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'h00, out_err_r, out_byte_r};
  assign out_tuser  = out_drv_r;

  // Memory writes come only from the copy walk
  a_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> $past(state_r == ST_COPY))
    else $error("memory write outside copy walk");

  // Undriven reads show the idle bus byte
  a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[7:0] == IDLE_BYTE))
    else $error("undriven result carries data");

  // A command error never comes with a driven read
  a_err_undriven: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> !out_tuser[0])
    else $error("command error on driven read");

  // Pointer stays inside the application area
  a_app_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_WR_APP) || (phase_r == PH_RD_APP)) |-> (int'(ptr_r) < APP_BYTES))
    else $error("application pointer out of range");

endmodule

FILE: src/owee_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module owee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
